### rtl/lcd_nibble_command_queue_unit_macros.svh
// ---------------------------------------------------------------------------
// LCD nibble command queue assertion macros
// Concurrent check wrappers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef LCD_NIBBLE_COMMAND_QUEUE_UNIT_MACROS_SVH
`define LCD_NIBBLE_COMMAND_QUEUE_UNIT_MACROS_SVH

// A condition that holds at every clock edge.
`define LNQ_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another in the next cycle.
`define LNQ_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lncq_pkg.sv
// ---------------------------------------------------------------------------
// LCD nibble command queue package
// Shared constants: defaults, request codes, LCD command bits and registers.
// ---------------------------------------------------------------------------
package lncq_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_CLEAR_PAD   = 3;
  localparam int ENTRY_W         = 9;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  localparam logic [2:0] MODE_PRINT  = 3'd0;
  localparam logic [2:0] MODE_SCROLL = 3'd1;
  localparam logic [2:0] MODE_CLEAR  = 3'd2;
  localparam logic [2:0] MODE_INIT   = 3'd3;
  localparam logic [2:0] MODE_DONE   = 3'd4;

  localparam logic [7:0] EN_MASK   = 8'h04;
  localparam logic [7:0] BL_MASK   = 8'h08;
  localparam logic [7:0] CMD_WAKE  = 8'h30;
  localparam logic [7:0] CMD_4BIT  = 8'h20;
  localparam logic [7:0] CMD_FUNC  = 8'h20;
  localparam logic [7:0] CMD_ENTRY = 8'h04;
  localparam logic [7:0] CMD_DISP  = 8'h08;
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  localparam logic [2:0] REG_BACKLIGHT = 3'd0;
  localparam logic [2:0] REG_ENTRY_LEFT = 3'd1;
  localparam logic [2:0] REG_DISPLAY_ON = 3'd2;
  localparam logic [2:0] REG_CURSOR_VIS = 3'd3;
  localparam logic [2:0] REG_CURSOR_BLINK = 3'd4;
  localparam logic [2:0] REG_TWO_LINE = 3'd5;
  localparam logic [2:0] REG_TALL_FONT = 3'd6;

endpackage

### rtl/lcd_nibble_command_queue_unit.sv
// ---------------------------------------------------------------------------
// LCD nibble command queue
// Queues LCD requests as RS plus byte entries and emits port expander bytes.
// ---------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_stall   mode, char_code, scroll_on
//  out       out_valid / out_stall expander_byte, transfer_end, refused, last
//  config    APB write/read        seven one-bit registers at 4*index
//
// An item is accepted in the idle state, its entries are written in the push
// state, an init then emits its wake bytes, and each entry is read from memory
// before its bytes are sent. The single-port entry memory sets this order.
// Reset needs no clearing pass. A stalled output holds the sequencer at its
// current byte.
module lcd_nibble_command_queue_unit import lncq_pkg::*; #(
  parameter int QUEUE_DEPTH       = DEF_QUEUE_DEPTH,
  parameter int CLEAR_PAD_ENTRIES = DEF_CLEAR_PAD
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        mode,
  input  logic [7:0]        char_code,
  input  logic              scroll_on,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        expander_byte,
  output logic              transfer_end,
  output logic              refused,
  output logic              last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NEED_W = $clog2(CLEAR_PAD_ENTRIES + 5);
  localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [NEED_W-1:0] NEED_ONE   = NEED_W'(1);
  localparam logic [NEED_W-1:0] NEED_CLEAR = NEED_W'(CLEAR_PAD_ENTRIES + 1);
  localparam logic [NEED_W-1:0] NEED_INIT  = NEED_W'(CLEAR_PAD_ENTRIES + 4);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PUSH   = 3'd1;
  localparam logic [2:0] ST_TRIPLE = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SEND   = 3'd4;
  localparam logic [2:0] ST_REFUSE = 3'd5;

  logic [ENTRY_W-1:0] pending_entries [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic              backlight_on, entry_to_left, display_on, cursor_visible;
  logic              cursor_blinks, two_line_mode, tall_font;
  logic [2:0]        state;
  logic              sending, display_shift;
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [2:0]        req_mode;
  logic [7:0]        req_char;
  logic [NEED_W-1:0] push_idx, push_need;
  logic [1:0]        phase, group;

  logic [NEED_W-1:0]  need;
  logic               fits;
  logic [ENTRY_W-1:0] entry;
  logic [7:0]         bl_bits, en_bits, func_cmd, entry_cmd, disp_cmd;
  logic [7:0]         send_byte, wake_byte;
  logic [3:0]         nibble;
  logic               can_load, cfg_write, out_load;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign can_load  = !out_valid || !out_stall;
  assign out_load  = can_load &&
                     (state == ST_TRIPLE || state == ST_SEND || state == ST_REFUSE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (mode)
      MODE_PRINT, MODE_SCROLL: need = NEED_ONE;
      MODE_CLEAR:              need = NEED_CLEAR;
      MODE_INIT:               need = NEED_INIT;
      default:                 need = '0;
    endcase
  end

  assign fits = ({1'b0, count} + (CNT_W + 1)'(need)) <= (CNT_W + 1)'(QUEUE_DEPTH);

  assign bl_bits   = backlight_on ? BL_MASK : 8'h00;
  assign en_bits   = (phase == 2'd1) ? EN_MASK : 8'h00;
  assign func_cmd  = CMD_FUNC | {4'b0, two_line_mode, tall_font, 2'b0};
  assign entry_cmd = CMD_ENTRY | {6'b0, entry_to_left, display_shift};
  assign disp_cmd  = CMD_DISP | {5'b0, display_on, cursor_visible, cursor_blinks};

  always_comb begin
    case (req_mode)
      MODE_PRINT:  entry = {1'b1, req_char};
      MODE_SCROLL: entry = {1'b0, entry_cmd};
      MODE_CLEAR:  entry = (push_idx == '0) ? {1'b0, CMD_CLEAR} : '0;
      MODE_INIT: begin
        if (push_idx == NEED_W'(0)) begin
          entry = {1'b0, func_cmd};
        end else if (push_idx == NEED_W'(1)) begin
          entry = {1'b0, entry_cmd};
        end else if (push_idx == NEED_W'(2)) begin
          entry = {1'b0, disp_cmd};
        end else if (push_idx == NEED_W'(3)) begin
          entry = {1'b0, CMD_CLEAR};
        end else begin
          entry = '0;
        end
      end
      default:     entry = '0;
    endcase
  end

  assign nibble    = (group == 2'd0) ? rd_data[7:4] : rd_data[3:0];
  assign send_byte = {nibble, 4'b0} | {7'b0, rd_data[8]} | bl_bits | en_bits;
  assign wake_byte = ((group == 2'd3) ? CMD_4BIT : CMD_WAKE) | bl_bits | en_bits;

  always_comb begin
    case (paddr[4:2])
      REG_BACKLIGHT:    prdata = DATA_W'(backlight_on);
      REG_ENTRY_LEFT:   prdata = DATA_W'(entry_to_left);
      REG_DISPLAY_ON:   prdata = DATA_W'(display_on);
      REG_CURSOR_VIS:   prdata = DATA_W'(cursor_visible);
      REG_CURSOR_BLINK: prdata = DATA_W'(cursor_blinks);
      REG_TWO_LINE:     prdata = DATA_W'(two_line_mode);
      REG_TALL_FONT:    prdata = DATA_W'(tall_font);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH) begin
      pending_entries[wr_ptr] <= entry;
    end
    if (state == ST_READ) begin
      rd_data <= pending_entries[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on   <= 1'b1;
      entry_to_left  <= 1'b0;
      display_on     <= 1'b1;
      cursor_visible <= 1'b1;
      cursor_blinks  <= 1'b1;
      two_line_mode  <= 1'b1;
      tall_font      <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_BACKLIGHT:    backlight_on   <= pwdata[0];
        REG_ENTRY_LEFT:   entry_to_left  <= pwdata[0];
        REG_DISPLAY_ON:   display_on     <= pwdata[0];
        REG_CURSOR_VIS:   cursor_visible <= pwdata[0];
        REG_CURSOR_BLINK: cursor_blinks  <= pwdata[0];
        REG_TWO_LINE:     two_line_mode  <= pwdata[0];
        REG_TALL_FONT:    tall_font      <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sending       <= 1'b0;
      display_shift <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_mode  <= mode;
            req_char  <= char_code;
            push_idx  <= '0;
            push_need <= need;
            if (mode <= MODE_DONE) begin
              if (!fits) begin
                state <= ST_REFUSE;
              end else if (mode == MODE_DONE) begin
                if (count == '0) begin
                  sending <= 1'b0;
                end else begin
                  state <= ST_READ;
                end
              end else begin
                if (mode == MODE_SCROLL) begin
                  display_shift <= scroll_on;
                end
                state <= ST_PUSH;
              end
            end
          end
        end
        ST_PUSH: begin
          wr_ptr   <= ptr_inc(wr_ptr);
          count    <= count + 1'b1;
          push_idx <= push_idx + 1'b1;
          phase    <= 2'd0;
          group    <= 2'd0;
          if (push_idx == push_need - 1'b1) begin
            if (req_mode == MODE_INIT) begin
              sending <= 1'b1;
              state   <= ST_TRIPLE;
            end else if (!sending) begin
              sending <= 1'b1;
              state   <= ST_READ;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_TRIPLE: begin
          if (can_load) begin
            expander_byte <= wake_byte;
            transfer_end  <= (phase == 2'd2);
            refused       <= 1'b0;
            last          <= 1'b0;
            if (phase == 2'd2) begin
              phase <= 2'd0;
              group <= group + 1'b1;
              if (group == 2'd3) begin
                state <= ST_READ;
              end
            end else begin
              phase <= phase + 1'b1;
            end
          end
        end
        ST_READ: begin
          rd_ptr <= ptr_inc(rd_ptr);
          count  <= count - 1'b1;
          phase  <= 2'd0;
          group  <= 2'd0;
          state  <= ST_SEND;
        end
        ST_SEND: begin
          if (can_load) begin
            expander_byte <= send_byte;
            transfer_end  <= (phase == 2'd2);
            refused       <= 1'b0;
            last          <= (phase == 2'd2) && (group == 2'd1);
            if (phase == 2'd2) begin
              phase <= 2'd0;
              group <= group + 1'b1;
              if (group == 2'd1) begin
                state <= ST_IDLE;
              end
            end else begin
              phase <= phase + 1'b1;
            end
          end
        end
        ST_REFUSE: begin
          if (can_load) begin
            expander_byte <= 8'h00;
            transfer_end  <= 1'b0;
            refused       <= 1'b1;
            last          <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "lcd_nibble_command_queue_unit_macros.svh"

  `LNQ_CHECK(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "Queue count exceeds depth.")
  `LNQ_CHECK(a_idle_empty, !(state == ST_IDLE && !sending) || count == '0, "Entries left unsent.")
  `LNQ_NEXT(a_dequeue, state == ST_READ, state == ST_SEND && count == $past(count) - 1'b1, "Bad dequeue.")
  `LNQ_CHECK(a_refusal_shape, !(out_valid && refused) || (last && !transfer_end && expander_byte == 8'h00), "Malformed refusal item.")

endmodule

### test/lcd_nibble_command_queue_unit_tb.sv
// ---------------------------------------------------------------------------
// LCD nibble command queue testbench
// Sends print, autoscroll, clear, init and transfer-done requests under
// random gaps and output stalls. A predictor of the entry queue and of the
// six-byte nibble transfers gives the expected expander bytes. Each result
// is checked against them in order. The register settings are changed
// between phases, including all-clear and all-set.
// ---------------------------------------------------------------------------
module lcd_nibble_command_queue_unit_tb import lncq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = DEF_QUEUE_DEPTH;
  localparam int PAD_ENTRIES = DEF_CLEAR_PAD;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 112;
  localparam logic [2:0] MODE_LAST_SPARE = 3'd7;
  localparam logic [8:0] RS_BIT = 9'h100;
  localparam logic [6:0] RESET_SETTINGS = 7'b0111101;

  typedef struct packed {
    logic [7:0] xbyte;
    logic       tend;
    logic       refusal;
    logic       fin;
  } lcd_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        mode = MODE_PRINT;
  logic [7:0]        char_code = 8'h00;
  logic              scroll_on = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        expander_byte;
  logic              transfer_end;
  logic              refused;
  logic              last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lcd_result_t expected_bytes[$];
  logic [8:0]  lcd_entries[$];
  bit          lcd_sending;
  bit          lcd_shift;
  bit          bl_on = 1'b1;
  bit          entry_left = 1'b0;
  bit          disp_on = 1'b1;
  bit          cur_vis = 1'b1;
  bit          cur_blink = 1'b1;
  bit          two_line = 1'b1;
  bit          tall = 1'b0;

  bit quiet;
  int stall_left;
  int errors;
  int items_accepted;
  int results_checked;
  int refusals_seen;
  int reg_writes;

  lcd_nibble_command_queue_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .char_code(char_code), .scroll_on(scroll_on),
    .out_valid(out_valid), .out_stall(out_stall),
    .expander_byte(expander_byte), .transfer_end(transfer_end),
    .refused(refused), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void expect_byte(logic [7:0] b, logic e);
    expected_bytes.push_back('{b, e, 1'b0, 1'b0});
  endfunction

  function automatic void expect_pulse(logic [7:0] b);
    expect_byte(b, 1'b0);
    expect_byte(b | EN_MASK, 1'b0);
    expect_byte(b, 1'b1);
  endfunction

  function automatic logic [7:0] backlight_bits();
    return bl_on ? BL_MASK : 8'h00;
  endfunction

  function automatic logic [7:0] entry_mode_byte();
    return CMD_ENTRY | (entry_left ? 8'h02 : 8'h00) | (lcd_shift ? 8'h01 : 8'h00);
  endfunction

  function automatic void send_next_entry();
    logic [8:0] e;
    logic [7:0] low_bits;
    if (lcd_entries.size() == 0) begin
      lcd_sending = 1'b0;
      return;
    end
    e = lcd_entries.pop_front();
    low_bits = {7'b0, e[8]} | backlight_bits();
    expect_pulse((e[7:0] & 8'hf0) | low_bits);
    expect_pulse({e[3:0], 4'h0} | low_bits);
  endfunction

  function automatic void start_if_idle();
    if (!lcd_sending) begin
      lcd_sending = 1'b1;
      send_next_entry();
    end
  endfunction

  function automatic void queue_clear_cmd();
    lcd_entries.push_back({1'b0, CMD_CLEAR});
    repeat (PAD_ENTRIES) lcd_entries.push_back(9'h000);
  endfunction

  function automatic void predict_request(logic [2:0] m, logic [7:0] ch, logic sc);
    int first;
    int need;
    first = expected_bytes.size();
    case (m)
      MODE_PRINT, MODE_SCROLL: need = 1;
      MODE_CLEAR: need = 1 + PAD_ENTRIES;
      MODE_INIT: need = 4 + PAD_ENTRIES;
      MODE_DONE: need = 0;
      default: return;
    endcase
    if (need > QDEPTH - lcd_entries.size()) begin
      expected_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      return;
    end
    case (m)
      MODE_PRINT: begin
        lcd_entries.push_back(RS_BIT | {1'b0, ch});
        start_if_idle();
      end
      MODE_SCROLL: begin
        lcd_shift = sc;
        lcd_entries.push_back({1'b0, entry_mode_byte()});
        start_if_idle();
      end
      MODE_CLEAR: begin
        queue_clear_cmd();
        start_if_idle();
      end
      MODE_INIT: begin
        repeat (3) expect_pulse(CMD_WAKE | backlight_bits());
        expect_pulse(CMD_4BIT | backlight_bits());
        lcd_entries.push_back({1'b0, CMD_FUNC | (two_line ? 8'h08 : 8'h00) |
                               (tall ? 8'h04 : 8'h00)});
        lcd_entries.push_back({1'b0, entry_mode_byte()});
        lcd_entries.push_back({1'b0, CMD_DISP | (disp_on ? 8'h04 : 8'h00) |
                               (cur_vis ? 8'h02 : 8'h00) | (cur_blink ? 8'h01 : 8'h00)});
        lcd_sending = 1'b1;
        send_next_entry();
        queue_clear_cmd();
      end
      default: send_next_entry();
    endcase
    if (expected_bytes.size() > first) expected_bytes[expected_bytes.size() - 1].fin = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) stall_left = quiet ? 0 : $urandom_range(0, 11);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    lcd_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (refused === 1'b1) refusals_seen++;
      if (expected_bytes.size() == 0) begin
        $error("result with nothing expected: expander_byte %02h", expander_byte);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (expander_byte !== want.xbyte) begin
          $error("expander_byte: expected %02h, got %02h", want.xbyte, expander_byte);
          errors++;
        end
        if (transfer_end !== want.tend) begin
          $error("transfer_end: expected %0b, got %0b", want.tend, transfer_end);
          errors++;
        end
        if (refused !== want.refusal) begin
          $error("refused: expected %0b, got %0b", want.refusal, refused);
          errors++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0b, got %0b", want.fin, last);
          errors++;
        end
      end
    end
  end

  task automatic send_request(input logic [2:0] m, input logic [7:0] ch, input logic sc);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    char_code <= ch;
    scroll_on <= sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(m, ch, sc);
    if (m <= MODE_DONE) items_accepted++;
  endtask

  task automatic wait_results_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(DATA_W - 1){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_BACKLIGHT: bl_on = v;
      REG_ENTRY_LEFT: entry_left = v;
      REG_DISPLAY_ON: disp_on = v;
      REG_CURSOR_VIS: cur_vis = v;
      REG_CURSOR_BLINK: cur_blink = v;
      REG_TWO_LINE: two_line = v;
      REG_TALL_FONT: tall = v;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_settings(input logic [6:0] bits);
    wait_results_idle();
    write_reg(REG_BACKLIGHT, bits[0]);
    write_reg(REG_ENTRY_LEFT, bits[1]);
    write_reg(REG_DISPLAY_ON, bits[2]);
    write_reg(REG_CURSOR_VIS, bits[3]);
    write_reg(REG_CURSOR_BLINK, bits[4]);
    write_reg(REG_TWO_LINE, bits[5]);
    write_reg(REG_TALL_FONT, bits[6]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_random_request();
    int r;
    logic [2:0] m;
    r = $urandom_range(0, 99);
    if (r < 6) m = 3'($urandom_range(MODE_DONE + 1, MODE_LAST_SPARE));
    else if (r < 14) m = MODE_DONE;
    else if (r < 22) m = MODE_INIT;
    else if (r < 34) m = MODE_CLEAR;
    else if (r < 48) m = MODE_SCROLL;
    else m = MODE_PRINT;
    send_request(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_init_sequence();
    send_request(MODE_INIT, 8'h00, 1'b0);
  endtask

  task automatic test_ignored_modes();
    for (int m = MODE_DONE + 1; m <= MODE_LAST_SPARE; m++) begin
      send_request(3'(m), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Fill the queue while a transfer is in flight, then hit it with every
  // request kind, free one slot and fill it exactly.
  task automatic test_queue_full();
    repeat (6) send_request(MODE_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_request(MODE_PRINT, 8'h00, 1'b0);
    send_request(MODE_PRINT, 8'hff, 1'b1);
    send_request(MODE_PRINT, 8'h5a, 1'b0);
    send_request(MODE_SCROLL, 8'h00, 1'b1);
    send_request(MODE_CLEAR, 8'h00, 1'b0);
    send_request(MODE_INIT, 8'h00, 1'b0);
    send_request(MODE_DONE, 8'h00, 1'b0);
    send_request(MODE_SCROLL, 8'hff, 1'b1);
  endtask

  task automatic test_random_traffic();
    int start;
    int round;
    int burst;
    int drains;
    int r;
    int left;
    start = items_accepted;
    round = 0;
    while (items_accepted - start < RANDOM_ITEMS) begin
      if (round % 3 == 0) begin
        case ((round / 3) % 4)
          0: load_settings(7'h00);
          1: load_settings(7'h7f);
          2: load_settings(7'($urandom_range(0, 127)));
          default: load_settings(RESET_SETTINGS);
        endcase
      end
      quiet = (round % 5 == 4);
      left = RANDOM_ITEMS - (items_accepted - start);
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 10);
      if (burst > left) burst = left;
      repeat (burst) send_random_request();
      left = RANDOM_ITEMS - (items_accepted - start);
      r = $urandom_range(0, 99);
      if (r < 70) drains = lcd_entries.size() + 1;
      else if (r < 85) drains = lcd_entries.size();
      else drains = $urandom_range(0, lcd_entries.size());
      if (drains > left) drains = left;
      repeat (drains) send_request(MODE_DONE, 8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)));
      round++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_init_sequence();
    test_ignored_modes();
    test_queue_full();
    test_random_traffic();
    wait_results_idle();
    $display("Run covered %0d requests and %0d checked results, %0d of them refusals.",
             items_accepted, results_checked, refusals_seen);
    $display("Register writes: %0d, across all-clear, all-set, reset and random settings.",
             reg_writes);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lncq_pkg.sv
rtl/lcd_nibble_command_queue_unit.sv
test/lcd_nibble_command_queue_unit_tb.sv
